// ===== src/mmpl_pkg.sv =====
// Shared types, codes and defaults for the mixed-mode palette line expander.
// No dependencies; mmpl_queue, mmpl_front, mmpl_back and the top import this package.
package mmpl_pkg;

  // Default geometry and palette size
  localparam int SCREEN_WIDTH_DEF  = 220;
  localparam int SCREEN_LINES_DEF  = 176;
  localparam int PALETTE_DEPTH_DEF = 512;

  // Palette bases of the packed modes
  localparam int NIBBLE_BASE = 256;
  localparam int CRUMB_BASE  = 272;

  // Entries of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Request commands
  typedef enum logic [1:0] {
    CMD_PIXEL   = 2'd0,
    CMD_PAL_WR  = 2'd1,
    CMD_MODE_WR = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  // Line-pair modes
  typedef enum logic [1:0] {
    MODE_BYTE   = 2'd0,
    MODE_NIBBLE = 2'd1,
    MODE_CRUMB  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // Work handed from front to back: a pixel byte or a palette write
  typedef struct packed {
    logic        is_pal_wr;
    mode_t       mode;
    logic [7:0]  data_byte;
    logic [8:0]  pal_index;
    logic [15:0] pal_value;
    logic [7:0]  line;
    logic        eol;
    logic        eof;
  } entry_t;

endpackage

// ===== src/mmpl_in_if.sv =====
// Input request channel: valid/ready handshake with the command payload.
// Depends on nothing.
interface mmpl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  data_byte;
  logic [8:0]  table_index;
  logic [15:0] table_value;

  modport source (output valid, cmd, data_byte, table_index, table_value, input ready);
  modport sink   (input valid, cmd, data_byte, table_index, table_value, output ready);
endinterface

// ===== src/mmpl_out_if.sv =====
// Output pixel channel: valid/ready handshake with one pixel and its flags.
// Depends on nothing.
interface mmpl_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_color;
  logic [7:0]  screen_line;
  logic        last_of_item;
  logic        end_of_line;
  logic        end_of_frame;

  modport source (output valid, pixel_color, screen_line, last_of_item, end_of_line,
                  end_of_frame, input ready);
  modport sink   (input valid, pixel_color, screen_line, last_of_item, end_of_line,
                  end_of_frame, output ready);
endinterface

// ===== src/mmpl_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module mmpl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/mmpl_queue.sv =====
// Short register queue of work entries between the front and the back.
// Depends on mmpl_pkg for entry_t and QUEUE_DEPTH.
module mmpl_queue
  import mmpl_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   head_valid,
  output logic   full
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t        slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head       = slots[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == CW'(QUEUE_DEPTH));

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== src/mmpl_front.sv =====
// Front part: takes requests, keeps line and byte counters and the mode table,
// classifies pixel bytes and forwards them and palette writes to the queue.
// Depends on mmpl_pkg, mmpl_in_if and mmpl_ram (mode table, instantiated here).
module mmpl_front
  import mmpl_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_LINES  = SCREEN_LINES_DEF,
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  mmpl_in_if.sink      pix_in,
  input  logic         q_full,
  output logic         q_push,
  output entry_t       q_entry
);

  localparam int PER_LINE_BYTE   = SCREEN_WIDTH / 2;
  localparam int PER_LINE_PACKED = SCREEN_WIDTH / 4;
  localparam int BW              = $clog2(PER_LINE_BYTE);
  localparam int LW              = (SCREEN_LINES > 1) ? $clog2(SCREEN_LINES) : 1;
  localparam int MODE_DEPTH      = (SCREEN_LINES + 1) / 2;
  localparam int MAW             = (MODE_DEPTH > 1) ? $clog2(MODE_DEPTH) : 1;

  logic [LW-1:0]  line;
  logic [BW-1:0]  byte_cnt;
  mode_t          line_mode;
  logic           mode_ok;
  logic           fetch_pend;
  logic           clr_busy;
  logic [MAW-1:0] clr_addr;

  cmd_t           cmd;
  logic           accept;
  logic [BW:0]    per_line;
  logic           eol;
  logic           eof;
  logic           mode_wr_ok;
  logic           pal_wr_ok;
  logic           invalidate;

  logic           mt_we;
  logic [MAW-1:0] mt_waddr;
  logic [1:0]     mt_wdata;
  logic           mt_re;
  logic [MAW-1:0] mt_raddr;
  logic [1:0]     mt_rdata;

  // Classify the request
  assign cmd          = cmd_t'(pix_in.cmd);
  assign pix_in.ready = !clr_busy && mode_ok && !q_full;
  assign accept       = pix_in.valid && pix_in.ready;

  assign per_line = (line_mode == MODE_NIBBLE || line_mode == MODE_CRUMB)
                    ? (BW+1)'(PER_LINE_PACKED) : (BW+1)'(PER_LINE_BYTE);
  assign eol = ({1'b0, byte_cnt} + (BW+1)'(1)) >= per_line;
  assign eof = eol && (({1'b0, line} + (LW+1)'(1)) >= (LW+1)'(SCREEN_LINES));

  assign mode_wr_ok = (32'(pix_in.table_index) < 32'(MODE_DEPTH)) &&
                      (pix_in.table_value <= 16'(MODE_CRUMB));
  assign pal_wr_ok  = 32'(pix_in.table_index) < 32'(PALETTE_DEPTH);

  assign invalidate = accept && (cmd == CMD_MODE_WR || cmd == CMD_RESTART ||
                                 (cmd == CMD_PIXEL && eol));

  // Forward pixel bytes and in-range palette writes
  assign q_push = accept && (cmd == CMD_PIXEL || (cmd == CMD_PAL_WR && pal_wr_ok));
  always_comb begin
    q_entry.is_pal_wr = (cmd == CMD_PAL_WR);
    q_entry.mode      = line_mode;
    q_entry.data_byte = pix_in.data_byte;
    q_entry.pal_index = pix_in.table_index;
    q_entry.pal_value = pix_in.table_value;
    q_entry.line      = 8'(line);
    q_entry.eol       = eol;
    q_entry.eof       = eof;
  end

  // Mode table ports: clearing pass, then mode writes; reads fetch the current pair
  assign mt_we    = clr_busy || (accept && cmd == CMD_MODE_WR && mode_wr_ok);
  assign mt_waddr = clr_busy ? clr_addr : MAW'(pix_in.table_index);
  assign mt_wdata = clr_busy ? 2'(MODE_BYTE) : pix_in.table_value[1:0];
  assign mt_re    = !clr_busy && !mode_ok && !fetch_pend;
  assign mt_raddr = MAW'(line >> 1);

  mmpl_ram #(
    .WIDTH (2),
    .DEPTH (MODE_DEPTH)
  ) u_mode_table (
    .clk   (clk),
    .we    (mt_we),
    .waddr (mt_waddr),
    .wdata (mt_wdata),
    .re    (mt_re),
    .raddr (mt_raddr),
    .rdata (mt_rdata)
  );

  // Clear the mode table after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + MAW'(1);
      if (clr_addr == MAW'(MODE_DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Keep the mode of the current line; refetch after a line change or table write
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_ok    <= 1'b0;
      fetch_pend <= 1'b0;
      line_mode  <= MODE_BYTE;
    end else if (!clr_busy) begin
      if (invalidate) begin
        mode_ok    <= 1'b0;
        fetch_pend <= 1'b0;
      end else if (fetch_pend) begin
        line_mode  <= mode_t'(mt_rdata);
        mode_ok    <= 1'b1;
        fetch_pend <= 1'b0;
      end else if (!mode_ok) begin
        fetch_pend <= 1'b1;
      end
    end
  end

  // Advance byte and line counters
  always_ff @(posedge clk) begin
    if (rst) begin
      line     <= '0;
      byte_cnt <= '0;
    end else if (accept) begin
      if (cmd == CMD_RESTART) begin
        line     <= '0;
        byte_cnt <= '0;
      end else if (cmd == CMD_PIXEL) begin
        if (eol) begin
          byte_cnt <= '0;
          line     <= eof ? '0 : line + LW'(1);
        end else begin
          byte_cnt <= byte_cnt + BW'(1);
        end
      end
    end
  end

endmodule

// ===== src/mmpl_back.sv =====
// Back part: carries out queued work, writing the palette or reading it once
// per output pixel; the palette read register is the output register.
// Depends on mmpl_pkg and mmpl_out_if; drives the palette RAM ports.
module mmpl_back
  import mmpl_pkg::*;
#(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
  localparam int PAW = $clog2(PALETTE_DEPTH)
) (
  input  logic            clk,
  input  logic            rst,
  input  entry_t          head,
  input  logic            head_valid,
  output logic            q_pop,
  output logic            pal_we,
  output logic [PAW-1:0]  pal_waddr,
  output logic [15:0]     pal_wdata,
  output logic            pal_re,
  output logic [PAW-1:0]  pal_raddr,
  input  logic [15:0]     pal_rdata,
  mmpl_out_if.source      pix_out
);

  logic [1:0] k;
  logic       out_valid;
  logic [7:0] out_line;
  logic       out_last;
  logic       out_eol;
  logic       out_eof;

  logic       advance;
  logic       issue;
  logic       px_issue;
  logic [1:0] k_last;
  logic       last;
  logic [9:0] rd_index;

  assign advance  = !out_valid || pix_out.ready;
  assign issue    = advance && head_valid;
  assign px_issue = issue && !head.is_pal_wr;
  assign k_last   = (head.mode == MODE_NIBBLE || head.mode == MODE_CRUMB) ? 2'd3 : 2'd1;
  assign last     = (k == k_last);
  assign q_pop    = issue && (head.is_pal_wr || last);

  // Palette index of pixel k of the byte
  always_comb begin
    unique case (head.mode)
      MODE_NIBBLE: rd_index = 10'(NIBBLE_BASE) +
                              10'(k[1] ? head.data_byte[3:0] : head.data_byte[7:4]);
      MODE_CRUMB:  rd_index = 10'(CRUMB_BASE) +
                              10'(head.data_byte[3'(6) - {k, 1'b0} +: 2]);
      default:     rd_index = 10'(head.data_byte);
    endcase
  end

  assign pal_re    = px_issue;
  assign pal_raddr = PAW'(rd_index);
  assign pal_we    = issue && head.is_pal_wr;
  assign pal_waddr = PAW'(head.pal_index);
  assign pal_wdata = head.pal_value;

  // Step through the pixels of the head byte
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (px_issue) begin
      k <= last ? 2'd0 : k + 2'd1;
    end
  end

  // Hold the output flags alongside the palette read data
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= px_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (px_issue) begin
      out_line <= head.line;
      out_last <= last;
      out_eol  <= last && head.eol;
      out_eof  <= last && head.eof;
    end
  end

  assign pix_out.valid        = out_valid;
  assign pix_out.pixel_color  = pal_rdata;
  assign pix_out.screen_line  = out_line;
  assign pix_out.last_of_item = out_last;
  assign pix_out.end_of_line  = out_eol;
  assign pix_out.end_of_frame = out_eof;

endmodule

// ===== src/mixed_mode_palette_line_expander.sv =====
// Mixed-mode palette line expander: screen bytes in, 2 or 4 RGB565 pixels out.
// The first pixel of a byte passes through the queue and the palette read register.
// Throughput: one pixel per cycle from the palette read port while the output is
// ready, 2 pixels per byte (byte mode) or 4 (packed modes); requests enter one per
// cycle while the 4-entry queue has room, pausing to fetch the line mode.
// Reset: the MODE_DEPTH entries (88 by default) of the mode table are cleared, ready low.
module mixed_mode_palette_line_expander
  import mmpl_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_LINES  = SCREEN_LINES_DEF,
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mmpl_in_if.sink     pix_in,
  mmpl_out_if.source  pix_out
);

  localparam int PAW = $clog2(PALETTE_DEPTH);

  logic           q_full;
  logic           q_push;
  entry_t         q_entry;
  logic           q_pop;
  entry_t         q_head;
  logic           q_head_valid;

  logic           pal_we;
  logic [PAW-1:0] pal_waddr;
  logic [15:0]    pal_wdata;
  logic           pal_re;
  logic [PAW-1:0] pal_raddr;
  logic [15:0]    pal_rdata;

  // Accept and classify requests
  mmpl_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_LINES  (SCREEN_LINES),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  // Decouple front and back
  mmpl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid),
    .full       (q_full)
  );

  // Expand bytes into pixels
  mmpl_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_valid (q_head_valid),
    .q_pop      (q_pop),
    .pal_we     (pal_we),
    .pal_waddr  (pal_waddr),
    .pal_wdata  (pal_wdata),
    .pal_re     (pal_re),
    .pal_raddr  (pal_raddr),
    .pal_rdata  (pal_rdata),
    .pix_out    (pix_out)
  );

  // Palette store
  mmpl_ram #(
    .WIDTH (16),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .re    (pal_re),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

endmodule
